// ===== design/bsc_pkg.sv =====
`default_nettype none

package bsc_pkg;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned NUM_WORDS   = 64;
  localparam int unsigned CAPACITY    = WORD_BITS * NUM_WORDS;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned CAP_W       = IDX_W + 1;
  localparam int unsigned OFF_W       = $clog2(WORD_BITS);
  localparam int unsigned WADDR_W     = $clog2(NUM_WORDS);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TEST  = 3'd0,
    CMD_SET   = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_FIRST = 3'd3,
    CMD_NEXT  = 3'd4
  } cmd_t;

  // Work for the back end after the front end has resolved the command.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TEST,
    OP_SET,
    OP_CLEAR,
    OP_SCAN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [WADDR_W-1:0] word;
    logic [OFF_W-1:0]   off;
  } item_t;

endpackage

`default_nettype wire

// ===== design/bsc_front.sv =====
`default_nettype none

module bsc_front (
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bsc_pkg::CMD_W-1:0]   in_command,
  input  wire logic [bsc_pkg::IDX_W-1:0]   in_bit_index,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output bsc_pkg::item_t                   push_item
);

  logic [bsc_pkg::CAP_W-1:0] idx_ext;
  logic [bsc_pkg::CAP_W-1:0] next_start;
  logic                      idx_ok;
  logic                      next_ok;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign idx_ext    = {1'b0, in_bit_index};
  assign next_start = idx_ext + bsc_pkg::CAP_W'(1);
  assign idx_ok     = idx_ext < bsc_pkg::CAP_W'(bsc_pkg::CAPACITY);
  assign next_ok    = next_start < bsc_pkg::CAP_W'(bsc_pkg::CAPACITY);

  always_comb begin
    push_item.op   = bsc_pkg::OP_NONE;
    push_item.word = bsc_pkg::WADDR_W'(idx_ext >> bsc_pkg::OFF_W);
    push_item.off  = bsc_pkg::OFF_W'(idx_ext);
    case (in_command)
      bsc_pkg::CMD_TEST: begin
        if (idx_ok) push_item.op = bsc_pkg::OP_TEST;
      end
      bsc_pkg::CMD_SET: begin
        if (idx_ok) push_item.op = bsc_pkg::OP_SET;
      end
      bsc_pkg::CMD_CLEAR: begin
        if (idx_ok) push_item.op = bsc_pkg::OP_CLEAR;
      end
      bsc_pkg::CMD_FIRST: begin
        push_item.op   = bsc_pkg::OP_SCAN;
        push_item.word = '0;
        push_item.off  = '0;
      end
      bsc_pkg::CMD_NEXT: begin
        // A start at or past the end finds nothing and skips the scan.
        push_item.word = bsc_pkg::WADDR_W'(next_start >> bsc_pkg::OFF_W);
        push_item.off  = bsc_pkg::OFF_W'(next_start);
        if (next_ok) push_item.op = bsc_pkg::OP_SCAN;
      end
      default: begin
        push_item.op = bsc_pkg::OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bsc_queue.sv =====
`default_nettype none

module bsc_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire bsc_pkg::item_t push_item,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output bsc_pkg::item_t pop_item
);

  bsc_pkg::item_t                entries_r [bsc_pkg::QUEUE_DEPTH];
  logic [bsc_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [bsc_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [bsc_pkg::QCNT_W-1:0]    count_r;
  logic [bsc_pkg::QPTR_W-1:0]    wr_ptr_nxt;
  logic [bsc_pkg::QPTR_W-1:0]    rd_ptr_nxt;
  logic [bsc_pkg::QCNT_W-1:0]    count_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = count_r != bsc_pkg::QCNT_W'(bsc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bsc_pkg::QPTR_W'(bsc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + bsc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bsc_pkg::QPTR_W'(bsc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + bsc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + bsc_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - bsc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/bsc_back.sv =====
`default_nettype none

module bsc_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire bsc_pkg::item_t             q_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_bit_value,
  output logic [bsc_pkg::IDX_W-1:0]       out_found_index,
  output logic                            out_found
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN
  } state_t;

  typedef logic [bsc_pkg::WORD_BITS-1:0] word_t;

  function automatic logic [bsc_pkg::OFF_W-1:0] lowest_one(input word_t w);
    logic [bsc_pkg::OFF_W-1:0] pos;
    pos = '0;
    for (int i = bsc_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) pos = bsc_pkg::OFF_W'(i);
    end
    return pos;
  endfunction

  // Bit map storage. A word that was never written since reset reads as zero.
  word_t                          mem [bsc_pkg::NUM_WORDS];
  logic [bsc_pkg::NUM_WORDS-1:0]  vld_r;
  word_t                          rd_data_r;
  logic                           rd_vld_r;

  state_t                         state_r, state_nxt;
  bsc_pkg::op_t                   op_r, op_nxt;
  logic [bsc_pkg::WADDR_W-1:0]    w_r, w_nxt;
  logic [bsc_pkg::OFF_W-1:0]      off_r, off_nxt;
  word_t                          mask_r, mask_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_bit_value_r, out_bit_value_nxt;
  logic [bsc_pkg::IDX_W-1:0]      out_found_index_r, out_found_index_nxt;
  logic                           out_found_r, out_found_nxt;

  logic                           rd_en;
  logic [bsc_pkg::WADDR_W-1:0]    rd_addr;
  logic                           wr_en;
  word_t                          wr_data;
  word_t                          cur_word;
  word_t                          masked;
  word_t                          bit_sel;

  assign cur_word = rd_vld_r ? rd_data_r : '0;
  assign masked   = cur_word & mask_r;
  assign bit_sel  = word_t'(1) << off_r;

  always_comb begin
    state_nxt           = state_r;
    op_nxt              = op_r;
    w_nxt               = w_r;
    off_nxt             = off_r;
    mask_nxt            = mask_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_bit_value_nxt   = out_bit_value_r;
    out_found_index_nxt = out_found_index_r;
    out_found_nxt       = out_found_r;
    q_ready             = 1'b0;
    rd_en               = 1'b0;
    rd_addr             = w_r;
    wr_en               = 1'b0;
    wr_data             = cur_word;
    case (state_r)
      S_IDLE: begin
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_ready  = 1'b1;
          op_nxt   = q_item.op;
          w_nxt    = q_item.word;
          off_nxt  = q_item.off;
          mask_nxt = {bsc_pkg::WORD_BITS{1'b1}} << q_item.off;
          if (q_item.op == bsc_pkg::OP_NONE) begin
            out_valid_nxt       = 1'b1;
            out_bit_value_nxt   = 1'b0;
            out_found_index_nxt = '0;
            out_found_nxt       = 1'b0;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = q_item.word;
            state_nxt = (q_item.op == bsc_pkg::OP_SCAN) ? S_SCAN : S_RMW;
          end
        end
      end
      S_RMW: begin
        if (op_r == bsc_pkg::OP_SET) begin
          wr_en   = 1'b1;
          wr_data = cur_word | bit_sel;
        end else if (op_r == bsc_pkg::OP_CLEAR) begin
          wr_en   = 1'b1;
          wr_data = cur_word & ~bit_sel;
        end
        out_valid_nxt       = 1'b1;
        out_bit_value_nxt   = cur_word[off_r];
        out_found_index_nxt = '0;
        out_found_nxt       = 1'b0;
        state_nxt           = S_IDLE;
      end
      S_SCAN: begin
        if (masked != '0) begin
          out_valid_nxt       = 1'b1;
          out_bit_value_nxt   = 1'b0;
          out_found_index_nxt = bsc_pkg::IDX_W'({w_r, lowest_one(masked)});
          out_found_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else if (w_r == bsc_pkg::WADDR_W'(bsc_pkg::NUM_WORDS - 1)) begin
          out_valid_nxt       = 1'b1;
          out_bit_value_nxt   = 1'b0;
          out_found_index_nxt = '0;
          out_found_nxt       = 1'b0;
          state_nxt           = S_IDLE;
        end else begin
          // Words after the first are searched from bit zero.
          w_nxt    = w_r + bsc_pkg::WADDR_W'(1);
          mask_nxt = '1;
          rd_en    = 1'b1;
          rd_addr  = w_r + bsc_pkg::WADDR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r              <= op_nxt;
    w_r               <= w_nxt;
    off_r             <= off_nxt;
    mask_r            <= mask_nxt;
    out_bit_value_r   <= out_bit_value_nxt;
    out_found_index_r <= out_found_index_nxt;
    out_found_r       <= out_found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[w_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[w_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_value   = out_bit_value_r;
  assign out_found_index = out_found_index_r;
  assign out_found       = out_found_r;

  a_rmw_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMW) |-> !out_valid_r)
    else $error("result register busy while a bit command finishes");

  a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !out_valid_r)
    else $error("result register busy while a search runs");

  a_found_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> !out_bit_value_r)
    else $error("search result carries a bit value");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> (state_r == S_IDLE))
    else $error("queue popped while a command is in progress");

endmodule

`default_nettype wire

// ===== design/bitmap_set_clear_find_next_core.sv =====
// A test, set or clear passes through the queue, the store's read register and the
// result register; a search reads one word a cycle from the store's single read port
// until a word holds a set bit at or past the start, or the last word is read.
// The back end takes the next command only once the last one has finished.
// Reset is synchronous and active low; per-word valid flags clear the whole map at once.
`default_nettype none

module bitmap_set_clear_find_next_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [bsc_pkg::CMD_W-1:0]  in_command,
  input  wire logic [bsc_pkg::IDX_W-1:0]  in_bit_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_bit_value,
  output logic [bsc_pkg::IDX_W-1:0]       out_found_index,
  output logic                            out_found
);

  logic           push_valid;
  logic           push_ready;
  bsc_pkg::item_t push_item;
  logic           q_valid;
  logic           q_ready;
  bsc_pkg::item_t q_item;

  bsc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_bit_index (in_bit_index),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  bsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  bsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_found_index (out_found_index),
    .out_found       (out_found)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned RESET_CYCLES = 3;
  localparam int unsigned RUN_LIMIT    = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned WINDOW_BITS  = 256;
  localparam int unsigned BURST_WORDS  = 40;
  localparam int unsigned PHASE_WORDS  = 650;

  // Command codes the block does not define.
  localparam logic [bsc_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [bsc_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                      bit_value;
    logic [bsc_pkg::IDX_W-1:0] found_index;
    logic                      found;
  } reply_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic [bsc_pkg::CMD_W-1:0] in_command   = '0;
  logic [bsc_pkg::IDX_W-1:0] in_bit_index = '0;
  logic                      out_ready    = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      out_bit_value;
  logic [bsc_pkg::IDX_W-1:0] out_found_index;
  logic                      out_found;

  bit [bsc_pkg::CAPACITY-1:0] bit_map;
  reply_t                     pending_replies[$];
  int unsigned                error_count   = 0;
  int unsigned                cycle_count   = 0;
  int unsigned                send_idle_pct = 0;
  int unsigned                recv_idle_pct = 0;

  bitmap_set_clear_find_next_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_bit_index    (in_bit_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_found_index (out_found_index),
    .out_found       (out_found)
  );

  always #HALF_PERIOD clk = ~clk;

  // Applies one command to the local copy of the map and returns the reply.
  function automatic reply_t apply_command(logic [bsc_pkg::CMD_W-1:0] cmd,
                                           logic [bsc_pkg::IDX_W-1:0] idx);
    reply_t      r;
    int unsigned start;
    r = '0;
    case (cmd)
      bsc_pkg::CMD_TEST, bsc_pkg::CMD_SET, bsc_pkg::CMD_CLEAR: begin
        r.bit_value = bit_map[idx];
        if (cmd == bsc_pkg::CMD_SET) begin
          bit_map[idx] = 1'b1;
        end else if (cmd == bsc_pkg::CMD_CLEAR) begin
          bit_map[idx] = 1'b0;
        end
      end
      bsc_pkg::CMD_FIRST, bsc_pkg::CMD_NEXT: begin
        start = (cmd == bsc_pkg::CMD_FIRST) ? 0 : int'(idx) + 1;
        for (int unsigned p = start; p < bsc_pkg::CAPACITY; p++) begin
          if (bit_map[p]) begin
            r.found       = 1'b1;
            r.found_index = p[bsc_pkg::IDX_W-1:0];
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Must be entered at a rising edge. Valid stays high after acceptance so the
  // next word can follow back to back.
  task automatic send_word(input logic [bsc_pkg::CMD_W-1:0] cmd,
                           input logic [bsc_pkg::IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_bit_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(apply_command(cmd, idx));
  endtask

  task automatic test_empty_map();
    send_word(bsc_pkg::CMD_TEST, '0);
    send_word(bsc_pkg::CMD_TEST, '1);
    send_word(bsc_pkg::CMD_FIRST, '0);
    send_word(bsc_pkg::CMD_NEXT, '0);
    send_word(bsc_pkg::CMD_NEXT, '1);
  endtask

  task automatic test_edge_bits();
    send_word(bsc_pkg::CMD_SET, '0);
    send_word(bsc_pkg::CMD_SET, '1);
    send_word(bsc_pkg::CMD_SET, bsc_pkg::IDX_W'(bsc_pkg::WORD_BITS - 1));
    send_word(bsc_pkg::CMD_SET, bsc_pkg::IDX_W'(bsc_pkg::WORD_BITS));
    send_word(bsc_pkg::CMD_SET, '0);
    send_word(bsc_pkg::CMD_FIRST, '1);
    send_word(bsc_pkg::CMD_NEXT, '0);
    send_word(bsc_pkg::CMD_NEXT, bsc_pkg::IDX_W'(bsc_pkg::WORD_BITS - 1));
    send_word(bsc_pkg::CMD_NEXT, bsc_pkg::IDX_W'(bsc_pkg::WORD_BITS));
    send_word(bsc_pkg::CMD_NEXT, bsc_pkg::IDX_W'(bsc_pkg::CAPACITY - 2));
    send_word(bsc_pkg::CMD_NEXT, '1);
    send_word(bsc_pkg::CMD_CLEAR, '1);
    send_word(bsc_pkg::CMD_CLEAR, '1);
    send_word(bsc_pkg::CMD_TEST, '1);
    send_word(bsc_pkg::CMD_CLEAR, '0);
    send_word(bsc_pkg::CMD_CLEAR, bsc_pkg::IDX_W'(bsc_pkg::WORD_BITS - 1));
    send_word(bsc_pkg::CMD_CLEAR, bsc_pkg::IDX_W'(bsc_pkg::WORD_BITS));
    send_word(bsc_pkg::CMD_FIRST, '0);
  endtask

  task automatic test_unused_commands();
    send_word(bsc_pkg::CMD_SET, bsc_pkg::IDX_W'(bsc_pkg::CAPACITY / 2));
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
      send_word(bsc_pkg::CMD_W'(c), bsc_pkg::IDX_W'(bsc_pkg::CAPACITY / 2));
    end
    send_word(bsc_pkg::CMD_TEST, bsc_pkg::IDX_W'(bsc_pkg::CAPACITY / 2));
  endtask

  // Most indexes fall in a window that moves every burst, so searches find
  // nearby bits often while the rest of the map stays sparse and long scans
  // still happen.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned               window_base;
    int unsigned               pick;
    logic [bsc_pkg::CMD_W-1:0] cmd;
    logic [bsc_pkg::IDX_W-1:0] idx;
    window_base = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % BURST_WORDS == 0) begin
        window_base = $urandom_range(bsc_pkg::CAPACITY - WINDOW_BITS);
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        cmd = bsc_pkg::CMD_TEST;
      end else if (pick < 45) begin
        cmd = bsc_pkg::CMD_SET;
      end else if (pick < 65) begin
        cmd = bsc_pkg::CMD_CLEAR;
      end else if (pick < 75) begin
        cmd = bsc_pkg::CMD_FIRST;
      end else if (pick < 95) begin
        cmd = bsc_pkg::CMD_NEXT;
      end else begin
        cmd = bsc_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        idx = bsc_pkg::IDX_W'(window_base + $urandom_range(WINDOW_BITS - 1));
      end else if (pick < 72) begin
        idx = bsc_pkg::IDX_W'($urandom_range(bsc_pkg::NUM_WORDS - 1) * bsc_pkg::WORD_BITS
                              + ($urandom_range(1) ? bsc_pkg::WORD_BITS - 1 : 0));
      end else begin
        idx = bsc_pkg::IDX_W'($urandom_range(bsc_pkg::CAPACITY - 1));
      end
      send_word(cmd, idx);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: bit_value %0d, found_index %0d, found %0d",
                 $time, out_bit_value, out_found_index, out_found);
      end else begin
        want = pending_replies.pop_front();
        check_field("bit_value", want.bit_value, out_bit_value);
        check_field("found_index", want.found_index, out_found_index);
        check_field("found", want.found, out_found);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    bit_map = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 82;
    test_empty_map();
    test_edge_bits();
    test_unused_commands();
    test_random_traffic(PHASE_WORDS);

    send_idle_pct = 82;
    recv_idle_pct = 35;
    test_random_traffic(PHASE_WORDS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(PHASE_WORDS);

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
